// File: rtl/fpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpc_pkg;
  localparam int CELLS = 4;
  localparam int MAX_WINDOW = 64;
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int GAIN_FRAC_BITS = 16;
  localparam int SUM_W = 38;
  localparam int COP_X_UM = 85000;
  localparam int COP_Y_UM = 45000;
  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_CAL_LF = 3'd1;
  localparam logic [2:0] REG_CAL_RB = 3'd4;
  localparam logic [2:0] REG_THRESH = 3'd5;

  typedef struct packed {
    logic start;
    logic clear;
    logic [AW-1:0] pos;
    logic [6:0] len;
  } lane_ctl_t;
endpackage
`default_nettype wire

// File: rtl/fpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fpc_in_if ();
  logic valid;
  logic ready;
  logic signed [23:0] raw_left_front;
  logic signed [23:0] raw_left_back;
  logic signed [23:0] raw_right_front;
  logic signed [23:0] raw_right_back;
  modport source (output valid, raw_left_front, raw_left_back, raw_right_front,
                  raw_right_back, input ready);
  modport sink (input valid, raw_left_front, raw_left_back, raw_right_front,
                raw_right_back, output ready);
endinterface

interface fpc_out_if ();
  logic valid;
  logic ready;
  logic [30:0] force_left_front;
  logic [30:0] force_left_back;
  logic [30:0] force_right_front;
  logic [30:0] force_right_back;
  logic [32:0] force_total;
  logic signed [17:0] cop_x;
  logic signed [16:0] cop_y;
  logic cop_valid;
  modport source (output valid, force_left_front, force_left_back, force_right_front,
                  force_right_back, force_total, cop_x, cop_y, cop_valid, input ready);
  modport sink (input valid, force_left_front, force_left_back, force_right_front,
                force_right_back, force_total, cop_x, cop_y, cop_valid, output ready);
endinterface
`default_nettype wire

// File: rtl/fpc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle (55 bits).
module fpc_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [54:0] dividend,
  input  wire logic [37:0] divisor,
  output logic             done,
  output logic [54:0]      quotient
);
  import fpc_pkg::*;
  logic [54:0] q_r;
  logic [38:0] rem_r;
  logic [37:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [38:0] sh;
  logic [38:0] sub;

  assign sh  = {rem_r[37:0], q_r[54]};
  assign sub = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        q_r    <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        if (!sub[38]) begin
          rem_r <= sub;
          q_r   <= {q_r[53:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[53:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd54) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign done = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// File: rtl/fpc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One load cell: calibrate, saturate, update window, average; a negative window sum gives zero.
module fpc_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fpc_pkg::lane_ctl_t ctl,
  input  wire logic signed [23:0] raw,
  input  wire logic [47:0]        cal,
  output logic                    done,
  output logic [30:0]             force_o
);
  import fpc_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SAT, S_RD, S_SUM, S_DIV} st_t;
  st_t st_r;
  logic signed [31:0] hist [MAX_WINDOW];
  logic signed [31:0] rd_r;
  logic signed [24:0] diff_r;
  logic signed [48:0] prod_r;
  logic signed [31:0] s_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [MAX_WINDOW-1:0] vld_r;
  logic [AW-1:0] pos_r;
  logic signed [48:0] q;
  logic signed [48:0] mag;
  logic signed [SUM_W-1:0] sum_nxt;
  logic dstart;
  logic ddone;
  logic [54:0] quo;
  logic [30:0] force_r;
  logic done_r;

  always_comb begin
    mag = prod_r < 0 ? -prod_r : prod_r;
    mag = mag >>> GAIN_FRAC_BITS;
    q = prod_r < 0 ? -mag : mag;
    sum_nxt = sum_r + SUM_W'(s_r) - SUM_W'(vld_r[pos_r] ? rd_r : 32'sd0);
  end

  assign dstart = (st_r == S_SUM) && !sum_nxt[SUM_W-1];

  fpc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart),
    .dividend({17'd0, sum_nxt}), .divisor({31'd0, ctl.len}),
    .done(ddone), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      vld_r  <= '0;
      sum_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.clear) begin
        vld_r <= '0;
        sum_r <= '0;
      end
      unique case (st_r)
        S_IDLE: if (ctl.start) begin
          diff_r <= 25'(raw) - 25'($signed(cal[47:24]));
          pos_r  <= ctl.pos;
          st_r   <= S_MUL;
        end
        S_MUL: begin
          prod_r <= diff_r * $signed(cal[23:0]);
          st_r   <= S_SAT;
        end
        S_SAT: begin
          if (q > 49'sd2147483647) s_r <= 32'h7fffffff;
          else if (q < -49'sd2147483648) s_r <= 32'h80000000;
          else s_r <= q[31:0];
          rd_r <= hist[pos_r];
          st_r <= S_RD;
        end
        S_RD: st_r <= S_SUM;
        S_SUM: begin
          sum_r <= sum_nxt;
          hist[pos_r] <= s_r;
          vld_r[pos_r] <= 1'b1;
          if (sum_nxt[SUM_W-1]) begin
            force_r <= '0;
            done_r  <= 1'b1;
            st_r    <= S_IDLE;
          end else st_r <= S_DIV;
        end
        S_DIV: if (ddone) begin
          force_r <= quo[30:0];
          done_r  <= 1'b1;
          st_r    <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
  assign done = done_r;
  assign force_o = force_r;
endmodule
`default_nettype wire

// File: rtl/fpc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Total, threshold and center of pressure with a shared divider.
module fpc_merge (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] f0,
  input  wire logic [30:0] f1,
  input  wire logic [30:0] f2,
  input  wire logic [30:0] f3,
  input  wire logic [32:0] thresh,
  output logic             done,
  output logic [32:0]      total,
  output logic signed [17:0] cx,
  output logic signed [16:0] cy,
  output logic             cvalid
);
  import fpc_pkg::*;
  typedef enum logic [2:0] {M_IDLE, M_MUL, M_X, M_Y, M_DONE} st_t;
  st_t st_r;
  logic [32:0] total_r;
  logic signed [33:0] dx_r, dy_r;
  logic [50:0] py_r;
  logic [50:0] pxm;
  logic sx_r, sy_r;
  logic signed [17:0] cx_r;
  logic signed [16:0] cy_r;
  logic cvalid_r, done_r, dstart, ddone;
  logic [54:0] dvd, quo;
  logic [33:0] ax, ay;
  logic [32:0] tsum;

  assign tsum = 33'(f0) + 33'(f1) + 33'(f2) + 33'(f3);
  assign ax = dx_r < 0 ? 34'(-dx_r) : 34'(dx_r);
  assign ay = dy_r < 0 ? 34'(-dy_r) : 34'(dy_r);
  assign pxm = 51'(ax[32:0] * 17'(COP_X_UM));
  assign dstart = (st_r == M_MUL && cvalid_r) || (st_r == M_X && ddone);
  assign dvd = st_r == M_MUL ? 55'(pxm) : 55'(py_r);

  fpc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dvd),
    .divisor({5'd0, total_r}), .done(ddone), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: if (start) begin
          total_r  <= tsum;
          cvalid_r <= tsum > thresh;
          dx_r <= 34'(f0) + 34'(f2) - 34'(f1) - 34'(f3);
          dy_r <= 34'(f0) + 34'(f1) - 34'(f2) - 34'(f3);
          cx_r <= '0;
          cy_r <= '0;
          st_r <= M_MUL;
        end
        M_MUL: begin
          py_r <= 51'(ay[32:0] * 17'(COP_Y_UM));
          sx_r <= dx_r < 0;
          sy_r <= dy_r < 0;
          st_r <= cvalid_r ? M_X : M_DONE;
          if (!cvalid_r) done_r <= 1'b1;
        end
        M_X: if (ddone) begin
          cx_r <= (quo > 55'(COP_X_UM)) ? (sx_r ? -18'sd85000 : 18'sd85000)
                 : (sx_r ? -$signed(18'(quo)) : $signed(18'(quo)));
          st_r <= M_Y;
        end
        M_Y: if (ddone) begin
          cy_r <= (quo > 55'(COP_Y_UM)) ? (sy_r ? -17'sd45000 : 17'sd45000)
                 : (sy_r ? -$signed(17'(quo)) : $signed(17'(quo)));
          done_r <= 1'b1;
          st_r <= M_DONE;
        end
        M_DONE: st_r <= M_IDLE;
        default: st_r <= M_IDLE;
      endcase
    end
  end
  assign done = done_r;
  assign total = total_r;
  assign cx = cx_r;
  assign cy = cy_r;
  assign cvalid = cvalid_r;
endmodule
`default_nettype wire

// File: rtl/foot_pressure_filter_cop.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: when the total exceeds the threshold the result follows the lane
// divide and two serial divides in the merge; otherwise only the lane divide,
// and no divide at all when every window sum is negative.
// Throughput: one item at a time; a new input is taken only after the output transfer.
// Reset: synchronous active low; history valid bits cleared at once, config
// registers to defaults; window writes also clear history immediately.
module foot_pressure_filter_cop (
  input  wire logic clk,
  input  wire logic rst_n,
  fpc_in_if.sink    in_ch,
  fpc_out_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);
  import fpc_pkg::*;
  logic [6:0] len_r;
  logic [47:0] cal_r [CELLS];
  logic [32:0] thr_r;
  logic [AW-1:0] pos_r;
  logic busy_r, ovalid_r, lane_wait_r;
  logic [CELLS-1:0] ldone_r, ldone;
  logic [30:0] lf [CELLS];
  lane_ctl_t ctl;
  logic acc, mdone, clr;
  logic [32:0] mtot;
  logic signed [17:0] mcx;
  logic signed [16:0] mcy;
  logic mcv;
  logic signed [23:0] raws [CELLS];

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;
  assign clr = cfg_we && cfg_index == REG_WINDOW;
  assign ctl = '{start: acc, clear: clr, pos: pos_r, len: len_r};
  assign raws[0] = in_ch.raw_left_front;
  assign raws[1] = in_ch.raw_left_back;
  assign raws[2] = in_ch.raw_right_front;
  assign raws[3] = in_ch.raw_right_back;

  for (genvar g = 0; g < CELLS; g++) begin : g_lane
    fpc_lane u_lane (.clk(clk), .rst_n(rst_n), .ctl(ctl), .raw(raws[g]),
                     .cal(cal_r[g]), .done(ldone[g]), .force_o(lf[g]));
  end

  fpc_merge u_merge (.clk(clk), .rst_n(rst_n),
    .start(lane_wait_r && &(ldone_r | ldone)),
    .f0(lf[0]), .f1(lf[1]), .f2(lf[2]), .f3(lf[3]), .thresh(thr_r),
    .done(mdone), .total(mtot), .cx(mcx), .cy(mcy), .cvalid(mcv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 7'd8;
      for (int i = 0; i < CELLS; i++) cal_r[i] <= 48'd65536;
      thr_r <= '0;
      pos_r <= '0;
      busy_r <= 1'b0;
      ovalid_r <= 1'b0;
      lane_wait_r <= 1'b0;
      ldone_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW) begin
          pos_r <= '0;
          if (cfg_wdata[6:0] == 7'd0) len_r <= 7'd1;
          else if (cfg_wdata[6:0] > 7'(MAX_WINDOW)) len_r <= 7'(MAX_WINDOW);
          else len_r <= cfg_wdata[6:0];
        end else if (cfg_index >= REG_CAL_LF && cfg_index <= REG_CAL_RB)
          cal_r[2'(cfg_index - REG_CAL_LF)] <= cfg_wdata;
        else if (cfg_index == REG_THRESH) thr_r <= cfg_wdata[32:0];
      end
      if (acc) begin
        busy_r <= 1'b1;
        lane_wait_r <= 1'b1;
        ldone_r <= '0;
        pos_r <= (7'(pos_r) + 7'd1 >= len_r) ? '0 : pos_r + 1'b1;
      end else if (lane_wait_r) begin
        if (&(ldone_r | ldone)) lane_wait_r <= 1'b0;
        else ldone_r <= ldone_r | ldone;
      end
      if (mdone) ovalid_r <= 1'b1;
      else if (out_ch.ready && ovalid_r) begin
        ovalid_r <= 1'b0;
        busy_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.force_left_front = lf[0];
  assign out_ch.force_left_back = lf[1];
  assign out_ch.force_right_front = lf[2];
  assign out_ch.force_right_back = lf[3];
  assign out_ch.force_total = mtot;
  assign out_ch.cop_x = mcx;
  assign out_ch.cop_y = mcy;
  assign out_ch.cop_valid = mcv;
endmodule
`default_nettype wire
